// ===== rtl/tetm_pkg.sv =====
// Shared types, constants and helpers of the task execution time monitor.
`timescale 1ns / 1ps

package tetm_pkg;

  localparam int MAX_TASKS = 10;
  localparam int SLOT_W    = 4;
  localparam int IDX_W     = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CNT_W     = $clog2(MAX_TASKS + 1);
  localparam int TAG_W     = 16;
  localparam int TIME_W    = 64;
  localparam int WORD_W    = 32;
  localparam int ACT_W     = 2;
  localparam int STAT_W    = 2;

  localparam logic [WORD_W-1:0] THRESHOLD_RESET = WORD_W'(50000000);

  typedef enum logic [ACT_W-1:0] {
    ACT_REGISTER = 2'd0,
    ACT_SWITCH   = 2'd1,
    ACT_READ     = 2'd2,
    ACT_NONE     = 2'd3
  } action_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_MEAS,
    ST_SCAN,
    ST_RD_IN,
    ST_LD_IN,
    ST_INC_SW,
    ST_WR_IN,
    ST_RD_RUN,
    ST_LD_RUN,
    ST_ADD_SUM,
    ST_ADD_CNT,
    ST_CMP_MAX,
    ST_CMP_MIN,
    ST_CMP_THR,
    ST_ADD_MISS,
    ST_WR_RUN,
    ST_RD_SLOT,
    ST_LD_SLOT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [WORD_W-1:0] count;
    logic [TIME_W-1:0] total;
    logic [TIME_W-1:0] longest;
    logic [TIME_W-1:0] shortest;
    logic [WORD_W-1:0] switches;
    logic [WORD_W-1:0] misses;
  } stat_rec_t;

  typedef struct packed {
    logic [TIME_W-1:0] a;
    logic [TIME_W-1:0] b;
    logic              sub;
  } alu_req_t;

  typedef struct packed {
    logic [TIME_W-1:0] sum;
    logic              carry;
  } alu_res_t;

  typedef struct packed {
    logic              done;
    logic              in_found;
    logic [SLOT_W-1:0] in_slot;
    logic              run_found;
    logic [SLOT_W-1:0] run_slot;
  } scan_res_t;

  function automatic stat_rec_t fresh_rec();
    stat_rec_t r;
    r.count    = '0;
    r.total    = '0;
    r.longest  = '0;
    r.shortest = '1;
    r.switches = '0;
    r.misses   = '0;
    return r;
  endfunction

endpackage

// ===== rtl/tetm_alu.sv =====
// Shared 64-bit add/subtract unit; subtract borrow doubles as the compare result.
`timescale 1ns / 1ps

module tetm_alu (
  input  tetm_pkg::alu_req_t req,
  output tetm_pkg::alu_res_t res
);

  logic [tetm_pkg::TIME_W:0] wide;

  always_comb begin
    if (req.sub) begin
      wide = {1'b0, req.a} - {1'b0, req.b};
    end else begin
      wide = {1'b0, req.a} + {1'b0, req.b};
    end
    res.sum   = wide[tetm_pkg::TIME_W-1:0];
    res.carry = wide[tetm_pkg::TIME_W];
  end

endmodule

// ===== rtl/tetm_stat_mem.sv =====
// Per-slot statistics memory, one write port and one registered read port.
`timescale 1ns / 1ps

module tetm_stat_mem (
  input  logic                       clk,
  input  logic                       we,
  input  logic [tetm_pkg::IDX_W-1:0] wr_addr,
  input  tetm_pkg::stat_rec_t        wr_data,
  input  logic [tetm_pkg::IDX_W-1:0] rd_addr,
  output tetm_pkg::stat_rec_t        rd_data
);

  tetm_pkg::stat_rec_t mem [tetm_pkg::MAX_TASKS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/tetm_tag_scan.sv =====
// Tag table and sequential lookup of the incoming and outgoing thread tags.
`timescale 1ns / 1ps

module tetm_tag_scan (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       tag_we,
  input  logic [tetm_pkg::IDX_W-1:0] tag_wr_idx,
  input  logic [tetm_pkg::TAG_W-1:0] tag_wr_data,
  input  logic                       scan_start,
  input  logic [tetm_pkg::CNT_W-1:0] used,
  input  logic [tetm_pkg::TAG_W-1:0] in_tag,
  input  logic [tetm_pkg::TAG_W-1:0] run_tag,
  output tetm_pkg::scan_res_t        res
);

  logic [tetm_pkg::TAG_W-1:0]  tags [tetm_pkg::MAX_TASKS];
  logic                        scanning;
  logic [tetm_pkg::CNT_W-1:0]  idx;
  logic                        in_found;
  logic [tetm_pkg::SLOT_W-1:0] in_slot;
  logic                        run_found;
  logic [tetm_pkg::SLOT_W-1:0] run_slot;
  logic [tetm_pkg::TAG_W-1:0]  cur_tag;
  logic                        at_end;

  always_ff @(posedge clk) begin
    if (tag_we) begin
      tags[tag_wr_idx] <= tag_wr_data;
    end
  end

  assign cur_tag = tags[idx[tetm_pkg::IDX_W-1:0]];
  assign at_end  = (idx == used);

  // Walk slots from zero up; keep the lowest match of each tag.
  always_ff @(posedge clk) begin
    if (rst) begin
      scanning  <= 1'b0;
      idx       <= '0;
      in_found  <= 1'b0;
      in_slot   <= '0;
      run_found <= 1'b0;
      run_slot  <= '0;
    end else if (scan_start) begin
      scanning  <= 1'b1;
      idx       <= '0;
      in_found  <= 1'b0;
      in_slot   <= '0;
      run_found <= 1'b0;
      run_slot  <= '0;
    end else if (scanning) begin
      if (at_end) begin
        scanning <= 1'b0;
      end else begin
        if (!in_found && cur_tag == in_tag) begin
          in_found <= 1'b1;
          in_slot  <= tetm_pkg::SLOT_W'(idx);
        end
        if (!run_found && cur_tag == run_tag) begin
          run_found <= 1'b1;
          run_slot  <= tetm_pkg::SLOT_W'(idx);
        end
        idx <= idx + tetm_pkg::CNT_W'(1);
      end
    end
  end

  assign res.done      = scanning && at_end;
  assign res.in_found  = in_found;
  assign res.in_slot   = in_slot;
  assign res.run_found = run_found;
  assign res.run_slot  = run_slot;

endmodule

// ===== rtl/task_execution_time_monitor.sv =====
// Top level: sequencer and datapath of the per-task execution time monitor.
//
//   channel  | signals                                   | transfer when
//   ---------+-------------------------------------------+------------------------
//   command  | start, busy, action, thread_tag, time_ns, | start && !busy
//            | slot                                      |
//   result   | done, status, slot_index, statistics,     | every cycle done is high
//            | missed_now, all_switches, measured_run    |
//   config   | cfg_valid, cfg_ready, cfg_data            | cfg_valid && cfg_ready
//
// Register goes from accept to DONE directly; read passes RD_SLOT and LD_SLOT first
// unless the slot is empty. Switch runs MEAS and the tag scan, then RD_IN..WR_IN if the
// incoming tag is registered and RD_RUN..WR_RUN if an outgoing run is measured on a
// registered tag. The tag scan checks one slot per cycle; the shared 64-bit adder gives each add its own state.
// Reset is synchronous; the table holds no entries and no thread runs after it.
// The receiver cannot stall: done is high for exactly one cycle per result.
`timescale 1ns / 1ps

module task_execution_time_monitor (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [tetm_pkg::ACT_W-1:0]  action,
  input  logic [tetm_pkg::TAG_W-1:0]  thread_tag,
  input  logic [tetm_pkg::TIME_W-1:0] time_ns,
  input  logic [tetm_pkg::SLOT_W-1:0] slot,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [tetm_pkg::WORD_W-1:0] cfg_data,
  output logic                        done,
  output logic [tetm_pkg::STAT_W-1:0] status,
  output logic [tetm_pkg::SLOT_W-1:0] slot_index,
  output logic [tetm_pkg::WORD_W-1:0] run_count,
  output logic [tetm_pkg::TIME_W-1:0] total_runtime,
  output logic [tetm_pkg::TIME_W-1:0] longest_run,
  output logic [tetm_pkg::TIME_W-1:0] shortest_run,
  output logic [tetm_pkg::WORD_W-1:0] task_switches,
  output logic [tetm_pkg::WORD_W-1:0] miss_count,
  output logic                        missed_now,
  output logic [tetm_pkg::TIME_W-1:0] all_switches,
  output logic [tetm_pkg::TIME_W-1:0] measured_run
);

  tetm_pkg::state_t state, state_next;

  tetm_pkg::action_t           act_q;
  logic [tetm_pkg::TAG_W-1:0]  tag_q;
  logic [tetm_pkg::TIME_W-1:0] now_q;
  logic [tetm_pkg::WORD_W-1:0] threshold;
  logic [tetm_pkg::CNT_W-1:0]  used;
  logic [tetm_pkg::TIME_W-1:0] switch_total;
  logic [tetm_pkg::TAG_W-1:0]  running_tag;
  logic [tetm_pkg::TIME_W-1:0] switch_time;
  logic                        running_valid;
  tetm_pkg::stat_rec_t         rec;
  logic [tetm_pkg::TIME_W-1:0] run_len;
  tetm_pkg::status_t           status_q;
  logic [tetm_pkg::SLOT_W-1:0] slot_q;
  logic                        rep_stats;
  logic                        missed_q;

  logic                        accept;
  logic                        room;
  logic                        slot_ok;
  logic                        run_go;
  tetm_pkg::alu_req_t          alu_req;
  tetm_pkg::alu_res_t          alu_res;
  tetm_pkg::scan_res_t         scan;
  logic                        scan_start;
  logic                        tag_we;
  logic                        mem_we;
  logic [tetm_pkg::IDX_W-1:0]  mem_wr_addr;
  tetm_pkg::stat_rec_t         mem_wr_data;
  logic [tetm_pkg::IDX_W-1:0]  mem_rd_addr;
  tetm_pkg::stat_rec_t         mem_rd_data;

  assign busy      = (state != tetm_pkg::ST_IDLE);
  assign cfg_ready = !busy;
  assign accept    = start && !busy;
  assign room      = (used < tetm_pkg::CNT_W'(tetm_pkg::MAX_TASKS));
  assign slot_ok   = ({1'b0, slot} < (tetm_pkg::SLOT_W + 1)'(used));
  assign run_go    = running_valid && scan.run_found;

  tetm_alu u_alu (
    .req (alu_req),
    .res (alu_res)
  );

  tetm_tag_scan u_scan (
    .clk         (clk),
    .rst         (rst),
    .tag_we      (tag_we),
    .tag_wr_idx  (used[tetm_pkg::IDX_W-1:0]),
    .tag_wr_data (thread_tag),
    .scan_start  (scan_start),
    .used        (used),
    .in_tag      (tag_q),
    .run_tag     (running_tag),
    .res         (scan)
  );

  tetm_stat_mem u_mem (
    .clk     (clk),
    .we      (mem_we),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      tetm_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (tetm_pkg::action_t'(action))
            tetm_pkg::ACT_REGISTER: state_next = tetm_pkg::ST_DONE;
            tetm_pkg::ACT_SWITCH:   state_next = tetm_pkg::ST_MEAS;
            tetm_pkg::ACT_READ:
              state_next = slot_ok ? tetm_pkg::ST_RD_SLOT : tetm_pkg::ST_DONE;
            default:                state_next = tetm_pkg::ST_IDLE;
          endcase
        end
      end
      tetm_pkg::ST_MEAS:     state_next = tetm_pkg::ST_SCAN;
      tetm_pkg::ST_SCAN: begin
        if (scan.done) begin
          priority if (scan.in_found) begin
            state_next = tetm_pkg::ST_RD_IN;
          end else if (run_go) begin
            state_next = tetm_pkg::ST_RD_RUN;
          end else begin
            state_next = tetm_pkg::ST_DONE;
          end
        end
      end
      tetm_pkg::ST_RD_IN:    state_next = tetm_pkg::ST_LD_IN;
      tetm_pkg::ST_LD_IN:    state_next = tetm_pkg::ST_INC_SW;
      tetm_pkg::ST_INC_SW:   state_next = tetm_pkg::ST_WR_IN;
      tetm_pkg::ST_WR_IN:
        state_next = run_go ? tetm_pkg::ST_RD_RUN : tetm_pkg::ST_DONE;
      tetm_pkg::ST_RD_RUN:   state_next = tetm_pkg::ST_LD_RUN;
      tetm_pkg::ST_LD_RUN:   state_next = tetm_pkg::ST_ADD_SUM;
      tetm_pkg::ST_ADD_SUM:  state_next = tetm_pkg::ST_ADD_CNT;
      tetm_pkg::ST_ADD_CNT:  state_next = tetm_pkg::ST_CMP_MAX;
      tetm_pkg::ST_CMP_MAX:  state_next = tetm_pkg::ST_CMP_MIN;
      tetm_pkg::ST_CMP_MIN:  state_next = tetm_pkg::ST_CMP_THR;
      tetm_pkg::ST_CMP_THR:  state_next = tetm_pkg::ST_ADD_MISS;
      tetm_pkg::ST_ADD_MISS: state_next = tetm_pkg::ST_WR_RUN;
      tetm_pkg::ST_WR_RUN:   state_next = tetm_pkg::ST_DONE;
      tetm_pkg::ST_RD_SLOT:  state_next = tetm_pkg::ST_LD_SLOT;
      tetm_pkg::ST_LD_SLOT:  state_next = tetm_pkg::ST_DONE;
      tetm_pkg::ST_DONE:     state_next = tetm_pkg::ST_IDLE;
      default:               state_next = tetm_pkg::ST_IDLE;
    endcase
  end

  // Unit operands, memory and scan control per state.
  always_comb begin
    alu_req     = '0;
    scan_start  = 1'b0;
    tag_we      = 1'b0;
    mem_we      = 1'b0;
    mem_wr_addr = slot_q[tetm_pkg::IDX_W-1:0];
    mem_wr_data = rec;
    mem_rd_addr = slot_q[tetm_pkg::IDX_W-1:0];
    unique case (state)
      tetm_pkg::ST_IDLE: begin
        if (accept && action == tetm_pkg::ACT_REGISTER && room) begin
          tag_we      = 1'b1;
          mem_we      = 1'b1;
          mem_wr_addr = used[tetm_pkg::IDX_W-1:0];
          mem_wr_data = tetm_pkg::fresh_rec();
        end
      end
      tetm_pkg::ST_MEAS: begin
        alu_req.a   = now_q;
        alu_req.b   = switch_time;
        alu_req.sub = 1'b1;
        scan_start  = 1'b1;
      end
      tetm_pkg::ST_RD_IN:  mem_rd_addr = scan.in_slot[tetm_pkg::IDX_W-1:0];
      tetm_pkg::ST_RD_RUN: mem_rd_addr = scan.run_slot[tetm_pkg::IDX_W-1:0];
      tetm_pkg::ST_INC_SW: begin
        alu_req.a = tetm_pkg::TIME_W'(rec.switches);
        alu_req.b = tetm_pkg::TIME_W'(1);
      end
      tetm_pkg::ST_WR_IN: begin
        mem_we      = 1'b1;
        mem_wr_addr = scan.in_slot[tetm_pkg::IDX_W-1:0];
      end
      tetm_pkg::ST_ADD_SUM: begin
        alu_req.a = rec.total;
        alu_req.b = run_len;
      end
      tetm_pkg::ST_ADD_CNT: begin
        alu_req.a = tetm_pkg::TIME_W'(rec.count);
        alu_req.b = tetm_pkg::TIME_W'(1);
      end
      // Borrow of a - b means b > a.
      tetm_pkg::ST_CMP_MAX: begin
        alu_req.a   = rec.longest;
        alu_req.b   = run_len;
        alu_req.sub = 1'b1;
      end
      tetm_pkg::ST_CMP_MIN: begin
        alu_req.a   = run_len;
        alu_req.b   = rec.shortest;
        alu_req.sub = 1'b1;
      end
      tetm_pkg::ST_CMP_THR: begin
        alu_req.a   = tetm_pkg::TIME_W'(threshold);
        alu_req.b   = run_len;
        alu_req.sub = 1'b1;
      end
      tetm_pkg::ST_ADD_MISS: begin
        alu_req.a = tetm_pkg::TIME_W'(rec.misses);
        alu_req.b = tetm_pkg::TIME_W'(missed_q);
      end
      tetm_pkg::ST_WR_RUN: begin
        mem_we      = 1'b1;
        mem_wr_addr = scan.run_slot[tetm_pkg::IDX_W-1:0];
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= tetm_pkg::ST_IDLE;
      threshold     <= tetm_pkg::THRESHOLD_RESET;
      used          <= '0;
      switch_total  <= '0;
      running_tag   <= '0;
      switch_time   <= '0;
      running_valid <= 1'b0;
      status_q      <= tetm_pkg::STAT_OK;
      rep_stats     <= 1'b0;
      missed_q      <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        threshold <= cfg_data;
      end
      unique case (state)
        tetm_pkg::ST_IDLE: begin
          if (accept) begin
            status_q  <= tetm_pkg::STAT_OK;
            rep_stats <= 1'b0;
            missed_q  <= 1'b0;
            unique case (tetm_pkg::action_t'(action))
              tetm_pkg::ACT_REGISTER: begin
                if (room) begin
                  used      <= used + tetm_pkg::CNT_W'(1);
                  rep_stats <= 1'b1;
                end else begin
                  status_q <= tetm_pkg::STAT_FULL;
                end
              end
              tetm_pkg::ACT_SWITCH: switch_total <= switch_total + tetm_pkg::TIME_W'(1);
              tetm_pkg::ACT_READ: begin
                if (slot_ok) begin
                  rep_stats <= 1'b1;
                end else begin
                  status_q <= tetm_pkg::STAT_EMPTY;
                end
              end
              default: begin
              end
            endcase
          end
        end
        tetm_pkg::ST_WR_IN, tetm_pkg::ST_WR_RUN: rep_stats <= 1'b1;
        tetm_pkg::ST_CMP_THR: missed_q <= alu_res.carry;
        tetm_pkg::ST_DONE: begin
          if (act_q == tetm_pkg::ACT_SWITCH) begin
            switch_time   <= now_q;
            running_tag   <= tag_q;
            running_valid <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    unique case (state)
      tetm_pkg::ST_IDLE: begin
        if (accept) begin
          act_q   <= tetm_pkg::action_t'(action);
          tag_q   <= thread_tag;
          now_q   <= time_ns;
          run_len <= '0;
          slot_q  <= '0;
          if (action == tetm_pkg::ACT_REGISTER && room) begin
            rec    <= tetm_pkg::fresh_rec();
            slot_q <= tetm_pkg::SLOT_W'(used);
          end
          if (action == tetm_pkg::ACT_READ) begin
            slot_q <= slot;
          end
        end
      end
      tetm_pkg::ST_MEAS:    run_len <= running_valid ? alu_res.sum : '0;
      tetm_pkg::ST_LD_IN, tetm_pkg::ST_LD_RUN, tetm_pkg::ST_LD_SLOT: rec <= mem_rd_data;
      tetm_pkg::ST_INC_SW:  rec.switches <= alu_res.sum[tetm_pkg::WORD_W-1:0];
      tetm_pkg::ST_WR_IN:   slot_q <= scan.in_slot;
      tetm_pkg::ST_ADD_SUM: rec.total <= alu_res.sum;
      tetm_pkg::ST_ADD_CNT: rec.count <= alu_res.sum[tetm_pkg::WORD_W-1:0];
      tetm_pkg::ST_CMP_MAX: begin
        if (alu_res.carry) begin
          rec.longest <= run_len;
        end
      end
      tetm_pkg::ST_CMP_MIN: begin
        if (alu_res.carry) begin
          rec.shortest <= run_len;
        end
      end
      tetm_pkg::ST_ADD_MISS: rec.misses <= alu_res.sum[tetm_pkg::WORD_W-1:0];
      tetm_pkg::ST_WR_RUN:   slot_q <= scan.run_slot;
      default: begin
      end
    endcase
  end

  assign done          = (state == tetm_pkg::ST_DONE);
  assign status        = status_q;
  assign slot_index    = slot_q;
  assign run_count     = rep_stats ? rec.count    : '0;
  assign total_runtime = rep_stats ? rec.total    : '0;
  assign longest_run   = rep_stats ? rec.longest  : '0;
  assign shortest_run  = rep_stats ? rec.shortest : '0;
  assign task_switches = rep_stats ? rec.switches : '0;
  assign miss_count    = rep_stats ? rec.misses   : '0;
  assign missed_now    = missed_q;
  assign all_switches  = switch_total;
  assign measured_run  = run_len;

`ifndef ASSERT_OFF
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held longer than one cycle");

  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    used <= tetm_pkg::CNT_W'(tetm_pkg::MAX_TASKS))
    else $error("slot count beyond table depth");

  a_reg_grows: assert property (@(posedge clk) disable iff (rst)
    accept && action == tetm_pkg::ACT_REGISTER && room
    |=> used == $past(used) + tetm_pkg::CNT_W'(1))
    else $error("register transfer did not claim a slot");

  a_full_zero: assert property (@(posedge clk) disable iff (rst)
    done && status == tetm_pkg::STAT_FULL
    |-> slot_index == '0 && run_count == '0 && measured_run == '0)
    else $error("full report carries statistics");

  a_miss_long: assert property (@(posedge clk) disable iff (rst)
    done && missed_now |-> measured_run > tetm_pkg::TIME_W'(threshold))
    else $error("deadline miss flagged on a short run");

  a_switch_count: assert property (@(posedge clk) disable iff (rst)
    accept && action == tetm_pkg::ACT_SWITCH
    |=> all_switches == $past(all_switches) + tetm_pkg::TIME_W'(1))
    else $error("switch transfer not counted");
`endif

endmodule

// ===== bench/tb.sv =====
// Self-checking bench for the task execution time monitor: directed cases, then random traffic.
`timescale 1ns / 1ps

module tb;
  import tetm_pkg::*;

  localparam int SETTLE_CYCLES = 40;
  localparam int STALL_LIMIT   = 1000;
  localparam int PHASE_ITEMS   = 200;

  logic                clk;
  logic                rst;
  logic                start;
  logic                busy;
  logic [ACT_W-1:0]    action;
  logic [TAG_W-1:0]    thread_tag;
  logic [TIME_W-1:0]   time_ns;
  logic [SLOT_W-1:0]   slot;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [WORD_W-1:0]   cfg_data;
  logic                done;
  logic [STAT_W-1:0]   status;
  logic [SLOT_W-1:0]   slot_index;
  logic [WORD_W-1:0]   run_count;
  logic [TIME_W-1:0]   total_runtime;
  logic [TIME_W-1:0]   longest_run;
  logic [TIME_W-1:0]   shortest_run;
  logic [WORD_W-1:0]   task_switches;
  logic [WORD_W-1:0]   miss_count;
  logic                missed_now;
  logic [TIME_W-1:0]   all_switches;
  logic [TIME_W-1:0]   measured_run;

  task_execution_time_monitor u_top (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .action       (action),
    .thread_tag   (thread_tag),
    .time_ns      (time_ns),
    .slot         (slot),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .done         (done),
    .status       (status),
    .slot_index   (slot_index),
    .run_count    (run_count),
    .total_runtime(total_runtime),
    .longest_run  (longest_run),
    .shortest_run (shortest_run),
    .task_switches(task_switches),
    .miss_count   (miss_count),
    .missed_now   (missed_now),
    .all_switches (all_switches),
    .measured_run (measured_run)
  );

  typedef struct {
    logic [STAT_W-1:0] status;
    logic [SLOT_W-1:0] slot_index;
    logic [WORD_W-1:0] run_count;
    logic [TIME_W-1:0] total_runtime;
    logic [TIME_W-1:0] longest_run;
    logic [TIME_W-1:0] shortest_run;
    logic [WORD_W-1:0] task_switches;
    logic [WORD_W-1:0] miss_count;
    logic              missed_now;
    logic [TIME_W-1:0] all_switches;
    logic [TIME_W-1:0] measured_run;
  } slot_report_t;

  slot_report_t pending_reports[$];

  // Profiler state as the bench expects it
  logic [TAG_W-1:0]  slot_tag      [MAX_TASKS];
  logic [TIME_W-1:0] slot_total    [MAX_TASKS];
  logic [TIME_W-1:0] slot_longest  [MAX_TASKS];
  logic [TIME_W-1:0] slot_shortest [MAX_TASKS];
  logic [WORD_W-1:0] slot_runs     [MAX_TASKS];
  logic [WORD_W-1:0] slot_switches [MAX_TASKS];
  logic [WORD_W-1:0] slot_misses   [MAX_TASKS];
  int                live_slots;
  logic [TIME_W-1:0] switch_tally;
  logic [TIME_W-1:0] last_switch_ns;
  logic [TAG_W-1:0]  current_tag;
  logic              thread_active;
  logic [WORD_W-1:0] miss_limit;

  logic [TIME_W-1:0] stamp_ns;
  int                burst_left;
  int                mismatches;
  int                stall_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int lookup_slot(logic [TAG_W-1:0] tag);
    for (int i = 0; i < live_slots; i++)
      if (slot_tag[i] == tag) return i;
    return -1;
  endfunction

  function automatic void fill_slot(inout slot_report_t r, input int s);
    r.slot_index    = SLOT_W'(s);
    r.run_count     = slot_runs[s];
    r.total_runtime = slot_total[s];
    r.longest_run   = slot_longest[s];
    r.shortest_run  = slot_shortest[s];
    r.task_switches = slot_switches[s];
    r.miss_count    = slot_misses[s];
  endfunction

  function automatic void profile_step(logic [ACT_W-1:0] act, logic [TAG_W-1:0] tag,
                                       logic [TIME_W-1:0] now_ns, logic [SLOT_W-1:0] rd_slot);
    slot_report_t      r;
    int                in_slot;
    int                run_slot;
    logic [TIME_W-1:0] run_ns;
    if (act == ACT_NONE) return;
    r = '{default: '0};
    r.status = STAT_OK;
    run_slot = -1;
    case (act)
      ACT_REGISTER: begin
        if (live_slots < MAX_TASKS) begin
          slot_tag[live_slots]      = tag;
          slot_total[live_slots]    = '0;
          slot_longest[live_slots]  = '0;
          slot_shortest[live_slots] = '1;
          slot_runs[live_slots]     = '0;
          slot_switches[live_slots] = '0;
          slot_misses[live_slots]   = '0;
          fill_slot(r, live_slots);
          live_slots++;
        end else begin
          r.status = STAT_FULL;
        end
      end
      ACT_SWITCH: begin
        switch_tally++;
        in_slot = lookup_slot(tag);
        if (in_slot >= 0) slot_switches[in_slot]++;
        if (thread_active) begin
          run_ns = now_ns - last_switch_ns;
          r.measured_run = run_ns;
          run_slot = lookup_slot(current_tag);
          if (run_slot >= 0) begin
            slot_total[run_slot] += run_ns;
            slot_runs[run_slot]++;
            if (run_ns > slot_longest[run_slot]) slot_longest[run_slot] = run_ns;
            if (run_ns < slot_shortest[run_slot]) slot_shortest[run_slot] = run_ns;
            if (run_ns > TIME_W'(miss_limit)) begin
              slot_misses[run_slot]++;
              r.missed_now = 1'b1;
            end
          end
        end
        last_switch_ns = now_ns;
        current_tag    = tag;
        thread_active  = 1'b1;
        // report the outgoing task when it was measured, else the incoming one
        if (run_slot >= 0) fill_slot(r, run_slot);
        else if (in_slot >= 0) fill_slot(r, in_slot);
      end
      default: begin
        if (int'(rd_slot) < live_slots) begin
          fill_slot(r, int'(rd_slot));
        end else begin
          r.status     = STAT_EMPTY;
          r.slot_index = rd_slot;
        end
      end
    endcase
    r.all_switches = switch_tally;
    pending_reports.push_back(r);
  endfunction

  function automatic void compare_field(string name, logic [TIME_W-1:0] want,
                                        logic [TIME_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : check_results
    slot_report_t want;
    if (!rst && done === 1'b1) begin
      if (pending_reports.size() == 0) begin
        $error("result with no pending command: slot_index 0x%0h", slot_index);
        mismatches++;
      end else begin
        want = pending_reports.pop_front();
        compare_field("status", TIME_W'(want.status), TIME_W'(status));
        compare_field("slot_index", TIME_W'(want.slot_index), TIME_W'(slot_index));
        compare_field("run_count", TIME_W'(want.run_count), TIME_W'(run_count));
        compare_field("total_runtime", want.total_runtime, total_runtime);
        compare_field("longest_run", want.longest_run, longest_run);
        compare_field("shortest_run", want.shortest_run, shortest_run);
        compare_field("task_switches", TIME_W'(want.task_switches), TIME_W'(task_switches));
        compare_field("miss_count", TIME_W'(want.miss_count), TIME_W'(miss_count));
        compare_field("missed_now", TIME_W'(want.missed_now), TIME_W'(missed_now));
        compare_field("all_switches", want.all_switches, all_switches);
        compare_field("measured_run", want.measured_run, measured_run);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("task_execution_time_monitor verification failed");
      $finish;
    end
  end

  // Hold the command until the transfer; between bursts of random length, idle for a random gap that may be zero.
  task automatic send_item(logic [ACT_W-1:0] act, logic [TAG_W-1:0] tag,
                           logic [TIME_W-1:0] now_ns, logic [SLOT_W-1:0] rd_slot);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk);
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    start      <= 1'b1;
    action     <= act;
    thread_tag <= tag;
    time_ns    <= now_ns;
    slot       <= rd_slot;
    do @(posedge clk); while (busy);
    profile_step(act, tag, now_ns, rd_slot);
  endtask

  task automatic switch_after(logic [TIME_W-1:0] delta, logic [TAG_W-1:0] tag);
    stamp_ns += delta;
    send_item(ACT_SWITCH, tag, stamp_ns, SLOT_W'($urandom));
  endtask

  // Drop start, drain all results, then allow for a command that returns nothing.
  task automatic settle();
    @(negedge clk);
    start <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_threshold(logic [WORD_W-1:0] value);
    settle();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    miss_limit = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_empty_table();
    send_item(ACT_READ, 16'h0000, 64'h0, 4'd0);
    send_item(ACT_READ, 16'hFFFF, '1, 4'd15);
    // first switch after reset: nothing is running, nothing measured
    send_item(ACT_SWITCH, 16'h1234, 64'd1000, 4'd0);
    send_item(ACT_NONE, 16'hFFFF, '1, 4'hF);
    // timestamp goes backward: the run wraps, no slot is credited
    stamp_ns = 64'd10;
    send_item(ACT_SWITCH, 16'h0000, stamp_ns, 4'd0);
  endtask

  task automatic test_register_fill();
    send_item(ACT_REGISTER, 16'h0000, 64'h0, 4'd0);
    send_item(ACT_REGISTER, 16'hFFFF, '1, 4'hF);
    send_item(ACT_REGISTER, 16'h00AA, 64'h0, 4'd0);
    send_item(ACT_REGISTER, 16'h00AA, 64'h0, 4'd0);
    for (int i = 4; i < MAX_TASKS; i++)
      send_item(ACT_REGISTER, TAG_W'($urandom), {$urandom, $urandom}, SLOT_W'($urandom));
    send_item(ACT_REGISTER, 16'h7777, 64'h0, 4'd0);
    send_item(ACT_READ, 16'h0000, 64'h0, SLOT_W'(MAX_TASKS - 1));
    send_item(ACT_READ, 16'h0000, 64'h0, SLOT_W'(MAX_TASKS));
  endtask

  task automatic test_switch_cases();
    // tag 0 is running and registered in slot 0
    switch_after(TIME_W'(miss_limit), 16'hFFFF);
    switch_after(TIME_W'(miss_limit) + 1, 16'h00AA);
    switch_after(64'd7, 16'h5555);
    switch_after(64'd3, 16'hFFFF);
    switch_after(64'd0, 16'hFFFF);
    stamp_ns = 64'd5;
    send_item(ACT_SWITCH, 16'h0000, stamp_ns, 4'd0);
  endtask

  task automatic random_traffic(int count);
    int                pick;
    logic [TAG_W-1:0]  tag;
    logic [TIME_W-1:0] delta;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        tag = (live_slots > 0 && $urandom_range(0, 9) != 0) ?
              slot_tag[$urandom_range(0, live_slots - 1)] : TAG_W'($urandom);
        case ($urandom_range(0, 3))
          0:       delta = TIME_W'($urandom_range(0, 1000));
          1:       delta = TIME_W'(miss_limit) + TIME_W'($urandom_range(0, 2)) - 1;
          2:       delta = TIME_W'($urandom);
          default: delta = {$urandom, $urandom};
        endcase
        switch_after(delta, tag);
      end else if (pick < 85) begin
        send_item(ACT_READ, TAG_W'($urandom), {$urandom, $urandom},
                  SLOT_W'($urandom_range(0, 15)));
      end else if (pick < 93) begin
        send_item(ACT_REGISTER, TAG_W'($urandom), {$urandom, $urandom}, SLOT_W'($urandom));
      end else begin
        send_item(ACT_NONE, TAG_W'($urandom), {$urandom, $urandom}, SLOT_W'($urandom));
      end
    end
  endtask

  task automatic test_threshold_sweep();
    logic [WORD_W-1:0] limits [4];
    limits = '{32'd0, 32'hFFFF_FFFF, WORD_W'($urandom_range(1, 1 << 24)), THRESHOLD_RESET};
    foreach (limits[i]) begin
      set_threshold(limits[i]);
      random_traffic(PHASE_ITEMS);
    end
  endtask

  initial begin
    rst        = 1'b1;
    start      = 1'b0;
    action     = ACT_NONE;
    thread_tag = '0;
    time_ns    = '0;
    slot       = '0;
    cfg_valid  = 1'b0;
    cfg_data   = '0;
    for (int i = 0; i < MAX_TASKS; i++) begin
      slot_tag[i]      = '0;
      slot_total[i]    = '0;
      slot_longest[i]  = '0;
      slot_shortest[i] = '0;
      slot_runs[i]     = '0;
      slot_switches[i] = '0;
      slot_misses[i]   = '0;
    end
    live_slots     = 0;
    switch_tally   = '0;
    last_switch_ns = '0;
    current_tag    = '0;
    thread_active  = 1'b0;
    miss_limit     = THRESHOLD_RESET;
    stamp_ns       = '0;
    burst_left     = 0;
    mismatches     = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_empty_table();
    test_register_fill();
    test_switch_cases();
    test_threshold_sweep();
    settle();

    if (mismatches == 0) $display("task_execution_time_monitor verification clean");
    else $display("task_execution_time_monitor verification failed");
    $finish;
  end

endmodule

// ===== task_execution_time_monitor.f =====
rtl/tetm_pkg.sv
rtl/tetm_alu.sv
rtl/tetm_stat_mem.sv
rtl/tetm_tag_scan.sv
rtl/task_execution_time_monitor.sv
bench/tb.sv
